// ===== rtl/spmf_pkg.sv =====
// Shared constants and types for the strict priority multilevel FIFO.
// No dependencies; imported by spmf_level_sel and the top level.
`default_nettype none

package spmf_pkg;

    localparam int LEVELS          = 16;
    localparam int DEPTH_PER_LEVEL = 16;
    localparam int TAG_BITS        = 16;

    // fixed field widths of the ports
    localparam int IN_LEVEL_W  = 4;
    localparam int OUT_TAG_W   = 16;
    localparam int OUT_LEVEL_W = 4;

    localparam int LVL_W   = $clog2(LEVELS);
    localparam int HEAD_W  = $clog2(DEPTH_PER_LEVEL);
    localparam int CNT_W   = $clog2(DEPTH_PER_LEVEL + 1);
    localparam int SUM_W   = HEAD_W + 1;
    localparam int CTRL_W  = HEAD_W + CNT_W;
    localparam int ENTRIES = LEVELS * DEPTH_PER_LEVEL;
    localparam int ADDR_W  = $clog2(ENTRIES);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic             hit;
        logic [LVL_W-1:0] lvl;
    } lvl_sel_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CTRL = 3'b010,
        S_DATA = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/spmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module spmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spmf_level_sel.sv =====
// Level choice: saturated push level, or priority encoder over occupancy for pop.
// Depends on spmf_pkg.
`default_nettype none

module spmf_level_sel
    import spmf_pkg::*;
(
    input  wire logic                  opcode,
    input  wire logic [IN_LEVEL_W-1:0] push_level,
    input  wire logic [LEVELS-1:0]     nonempty,
    output lvl_sel_t                   sel
);

    always_comb
    begin
        sel = '0;
        if (opcode == OP_PUSH)
        begin
            sel.hit = 1'b1;
            if (32'(push_level) >= 32'(LEVELS))
            begin
                sel.lvl = LVL_W'(LEVELS - 1);
            end
            else
            begin
                sel.lvl = LVL_W'(push_level);
            end
        end
        else
        begin
            // highest set bit wins
            for (int i = 0; i < LEVELS; i++)
            begin
                if (nonempty[i])
                begin
                    sel.hit = 1'b1;
                    sel.lvl = LVL_W'(i);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/strict_priority_multi_fifo_unit.sv =====
// Top level of the strict priority multilevel FIFO task queue.
// Depends on spmf_pkg, spmf_ram and spmf_level_sel.
// Usage
//   Input (in_valid/in_ready): a transfer is a push (opcode 0: push_level,
//   task_tag) or a pop (opcode 1). Levels past the last saturate to the top.
//   Output (out_valid/out_ready): one result per input transfer, in order.
//   A push returns overflow=1 when its level was full (tag dropped). A pop
//   returns found, popped_tag, popped_level from the highest non-empty
//   level, or all zeros when every level is empty.
// Timing
//   Head/count words per level sit in a small synchronous RAM, the tags in
//   a LEVELS*DEPTH_PER_LEVEL entry RAM. The control word is read first (state
//   S_CTRL); a hit pop adds a tag RAM read (state S_DATA). The result register
//   loads from S_CTRL for a push or an empty pop, from S_DATA for a hit pop.
//   in_ready is high again right after that load, so no new transfer is taken
//   before the last result is loaded. One item in flight: no RAM overlap.
// Reset
//   Clears state, out_valid, occupancy and control-word valid bits; tag RAM is not cleared.
// Stall
//   While out_ready is low the result holds; a finished item waits in its
//   state and in_ready stays low.
`default_nettype none

module strict_priority_multi_fifo_unit
    import spmf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   opcode,
    input  wire logic [IN_LEVEL_W-1:0]  push_level,
    input  wire logic [15:0]            task_tag,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        found,
    output logic [OUT_TAG_W-1:0]        popped_tag,
    output logic [OUT_LEVEL_W-1:0]      popped_level,
    output logic                        overflow
);

    // control state
    state_t              state_reg, state_next;
    logic [LEVELS-1:0]   nonempty_reg, nonempty_next;
    logic [LEVELS-1:0]   ctrl_vld_reg, ctrl_vld_next;
    logic                out_valid_reg, out_valid_next;

    // per-item payload registers
    logic                op_reg, op_next;
    logic                hit_reg, hit_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                vld_reg, vld_next;

    // result register
    logic                 found_reg, found_next;
    logic [OUT_TAG_W-1:0] ptag_reg, ptag_next;
    logic [OUT_LEVEL_W-1:0] plvl_reg, plvl_next;
    logic                 ovf_reg, ovf_next;

    lvl_sel_t sel;

    // RAM ports
    logic                ctrl_rd_en, ctrl_wr_en;
    logic [CTRL_W-1:0]   ctrl_rd_data, ctrl_wr_data;
    logic                ent_rd_en, ent_wr_en;
    logic [ADDR_W-1:0]   ent_rd_addr, ent_wr_addr;
    logic [TAG_BITS-1:0] ent_rd_data;

    // control-word decode
    logic [HEAD_W-1:0]   cur_head, head_inc, tail_slot;
    logic [CNT_W-1:0]    cur_cnt;
    logic [SUM_W-1:0]    tail_sum;
    logic                lvl_full;
    logic [ADDR_W-1:0]   lvl_base;
    logic                accept, advance;

    spmf_level_sel u_sel (
        .opcode     (opcode),
        .push_level (push_level),
        .nonempty   (nonempty_reg),
        .sel        (sel)
    );

    spmf_ram #(
        .WIDTH (CTRL_W),
        .DEPTH (LEVELS)
    ) u_ctrl_ram (
        .clk     (clk),
        .wr_en   (ctrl_wr_en),
        .wr_addr (lvl_reg),
        .wr_data (ctrl_wr_data),
        .rd_en   (ctrl_rd_en),
        .rd_addr (sel.lvl),
        .rd_data (ctrl_rd_data)
    );

    spmf_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (tag_reg),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign accept       = in_valid && in_ready;
    assign advance      = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign popped_tag   = ptag_reg;
    assign popped_level = plvl_reg;
    assign overflow     = ovf_reg;

    // a control word never written reads as head 0, count 0
    assign cur_head  = vld_reg ? ctrl_rd_data[HEAD_W-1:0] : '0;
    assign cur_cnt   = vld_reg ? ctrl_rd_data[CTRL_W-1:HEAD_W] : '0;
    assign lvl_full  = (cur_cnt == CNT_W'(DEPTH_PER_LEVEL));
    assign tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_cnt);
    assign tail_slot = (tail_sum >= SUM_W'(DEPTH_PER_LEVEL))
                     ? HEAD_W'(tail_sum - SUM_W'(DEPTH_PER_LEVEL))
                     : HEAD_W'(tail_sum);
    assign head_inc  = (cur_head == HEAD_W'(DEPTH_PER_LEVEL - 1))
                     ? '0 : cur_head + HEAD_W'(1);
    assign lvl_base  = ADDR_W'(lvl_reg) * ADDR_W'(DEPTH_PER_LEVEL);

    assign ent_wr_addr = lvl_base + ADDR_W'(tail_slot);
    assign ent_rd_addr = lvl_base + ADDR_W'(cur_head);

    always_comb
    begin
        state_next     = state_reg;
        nonempty_next  = nonempty_reg;
        ctrl_vld_next  = ctrl_vld_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        hit_next       = hit_reg;
        lvl_next       = lvl_reg;
        tag_next       = tag_reg;
        vld_next       = vld_reg;
        found_next     = found_reg;
        ptag_next      = ptag_reg;
        plvl_next      = plvl_reg;
        ovf_next       = ovf_reg;
        ctrl_rd_en     = 1'b0;
        ctrl_wr_en     = 1'b0;
        ctrl_wr_data   = '0;
        ent_rd_en      = 1'b0;
        ent_wr_en      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // fetch the chosen level's control word
                    ctrl_rd_en = 1'b1;
                    op_next    = opcode;
                    hit_next   = sel.hit;
                    lvl_next   = sel.lvl;
                    tag_next   = TAG_BITS'(task_tag);
                    vld_next   = ctrl_vld_reg[sel.lvl];
                    state_next = S_CTRL;
                end
            end
            S_CTRL:
            begin
                if (op_reg == OP_POP && hit_reg)
                begin
                    // pop from a non-empty level: fetch head tag, retire head
                    ent_rd_en              = 1'b1;
                    ctrl_wr_en             = 1'b1;
                    ctrl_wr_data           = {cur_cnt - CNT_W'(1), head_inc};
                    ctrl_vld_next[lvl_reg] = 1'b1;
                    nonempty_next[lvl_reg] = (cur_cnt != CNT_W'(1));
                    state_next             = S_DATA;
                end
                else if (advance)
                begin
                    found_next     = 1'b0;
                    ptag_next      = '0;
                    plvl_next      = '0;
                    ovf_next       = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (op_reg == OP_PUSH)
                    begin
                        if (lvl_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ent_wr_en              = 1'b1;
                            ctrl_wr_en             = 1'b1;
                            ctrl_wr_data           = {cur_cnt + CNT_W'(1), cur_head};
                            ctrl_vld_next[lvl_reg] = 1'b1;
                            nonempty_next[lvl_reg] = 1'b1;
                        end
                    end
                end
            end
            S_DATA:
            begin
                // tag RAM data holds until the result register frees
                if (advance)
                begin
                    found_next     = 1'b1;
                    ptag_next      = OUT_TAG_W'(ent_rd_data);
                    plvl_next      = OUT_LEVEL_W'(lvl_reg);
                    ovf_next       = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nonempty_reg  <= '0;
            ctrl_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            ctrl_vld_reg  <= ctrl_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        hit_reg   <= hit_next;
        lvl_reg   <= lvl_next;
        tag_reg   <= tag_next;
        vld_reg   <= vld_next;
        found_reg <= found_next;
        ptag_reg  <= ptag_next;
        plvl_reg  <= plvl_next;
        ovf_reg   <= ovf_next;
    end

endmodule

`default_nettype wire
